/* rtl/simple_regex_line_matcher_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the regex line matcher
// Shared property wrappers, clocked on clk with asynchronous reset arst_n.
// ----------------------------------------------------------------------------
`ifndef SIMPLE_REGEX_LINE_MATCHER_DEFINES_SVH
`define SIMPLE_REGEX_LINE_MATCHER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRLM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srlm assertion failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define SRLM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srlm assertion failed one cycle later");

`endif

/* rtl/srlm_pkg.sv */
// ----------------------------------------------------------------------------
// srlm_pkg
// Types and constants shared by the regex line matcher and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srlm_pkg;

	localparam int CHAR_W    = 8;
	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 64;
	localparam int TCOUNT_W  = 4;

	localparam logic [REG_IDX_W-1:0] REG_PATTERN_CHARS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_WILDCARD_MASK = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_STAR_MASK     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TOKEN_COUNT   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ANCHOR_START  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ANCHOR_END    = 3'd5;

	// Static setup of one token cell.
	typedef struct packed {
		logic [CHAR_W-1:0] chr;
		logic              wild;
		logic              star;
		logic              en;
	} srlm_cell_cfg_t;

	// What one cell hands on to its neighbour and to the top level.
	typedef struct packed {
		logic active;
		logic v;
		logic carry;
		logic advance;
	} srlm_cell_out_t;

endpackage

`default_nettype wire

/* rtl/srlm_cell.sv */
// ----------------------------------------------------------------------------
// srlm_cell
// One token position of the NFA: holds its activity bit, extends the star
// closure to its neighbour and passes a successful literal match onwards.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srlm_cell
	import srlm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire srlm_cell_cfg_t    cfg,
	input  wire logic [CHAR_W-1:0] text_char,
	input  wire logic              step,
	input  wire logic              clear,
	input  wire logic              carry_in,
	input  wire logic              advance_in,
	output srlm_cell_out_t         cell_out
);

	logic active_q;
	logic v;
	logic hit;
	logic matched;

	assign v       = active_q | carry_in;
	assign hit     = cfg.wild | (cfg.chr == text_char);
	assign matched = v & hit & cfg.en;

	assign cell_out.active  = active_q;
	assign cell_out.v       = v;
	assign cell_out.carry   = v & cfg.star & cfg.en;
	assign cell_out.advance = matched & ~cfg.star;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (clear) begin
			active_q <= 1'b0;
		end else if (step) begin
			// A starred token stays put on a match; a plain one moves on.
			active_q <= (matched & cfg.star) | advance_in;
		end
	end

endmodule

`default_nettype wire

/* rtl/simple_regex_line_matcher.sv */
// ----------------------------------------------------------------------------
// simple_regex_line_matcher
// Streams the characters of a line and reports at each end of line whether
// the line contains a match for a small configured regular expression.
// ----------------------------------------------------------------------------
//  Channel  Signals                               Direction  Beat
//  cfg      cfg_valid cfg_ready cfg_index cfg_data in        one register write
//  in       in_valid in_ready text_char end_of_line in       one character or end
//  out      out_valid out_ready line_matched      out        one line result
//
// A new beat is accepted each cycle while in_ready is high.
// The active set lives in a row of token cells that all update together, so
// the star closure ripples combinationally through the whole row.
// A line result appears in the cycle after its end-of-line beat.
// in_ready falls only while a result is held and out_ready is low.
// Reset clears configuration to zero and starts a new line; cfg_ready is
// always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "simple_regex_line_matcher_defines.svh"

module simple_regex_line_matcher
	import srlm_pkg::*;
#(
	parameter int MAX_TOKENS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire logic [CHAR_W-1:0]    text_char,
	input  wire logic                 end_of_line,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      logic                 line_matched
);

	localparam int NW = $clog2(MAX_TOKENS + 1);

	logic [CHAR_W*8-1:0]  pattern_q;
	logic [7:0]           wildcard_q;
	logic [7:0]           star_q;
	logic [TCOUNT_W-1:0]  token_count_q;
	logic                 anchor_start_q;
	logic                 anchor_end_q;

	logic                 line_start_q;
	logic                 found_q;
	logic                 act_last_q;
	logic                 out_valid_q;
	logic                 line_matched_q;

	logic [NW-1:0]        n_use;
	logic                 seed;
	logic                 in_beat;
	logic                 step;
	logic                 clear;
	logic [MAX_TOKENS:0]  v_full;
	logic [MAX_TOKENS:0]  act_full;
	logic                 accept_now;

	srlm_cell_cfg_t       cell_cfg [MAX_TOKENS];
	srlm_cell_out_t       cell_out [MAX_TOKENS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q      <= '0;
			wildcard_q     <= '0;
			star_q         <= '0;
			token_count_q  <= '0;
			anchor_start_q <= 1'b0;
			anchor_end_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PATTERN_CHARS: pattern_q      <= cfg_data;
				REG_WILDCARD_MASK: wildcard_q     <= cfg_data[7:0];
				REG_STAR_MASK:     star_q         <= cfg_data[7:0];
				REG_TOKEN_COUNT:   token_count_q  <= cfg_data[TCOUNT_W-1:0];
				REG_ANCHOR_START:  anchor_start_q <= cfg_data[0];
				REG_ANCHOR_END:    anchor_end_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Counts above the cell row are treated as the full row.
	assign n_use = (token_count_q > TCOUNT_W'(MAX_TOKENS)) ? NW'(MAX_TOKENS)
	                                                       : NW'(token_count_q);

	assign in_ready = ~out_valid_q | out_ready;
	assign in_beat  = in_valid & in_ready;
	assign step     = in_beat & ~end_of_line;
	assign clear    = in_beat & end_of_line;
	assign seed     = ~anchor_start_q | line_start_q;

	for (genvar p = 0; p < MAX_TOKENS; p++) begin : g_cell
		logic carry_in;
		logic advance_in;

		assign cell_cfg[p].chr  = pattern_q[CHAR_W*p +: CHAR_W];
		assign cell_cfg[p].wild = wildcard_q[p];
		assign cell_cfg[p].star = star_q[p];
		assign cell_cfg[p].en   = (NW'(p) < n_use);

		if (p == 0) begin : g_head
			assign carry_in   = seed;
			assign advance_in = 1'b0;
		end else begin : g_link
			assign carry_in   = cell_out[p-1].carry;
			assign advance_in = cell_out[p-1].advance;
		end

		srlm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cfg        (cell_cfg[p]),
			.text_char  (text_char),
			.step       (step),
			.clear      (clear),
			.carry_in   (carry_in),
			.advance_in (advance_in),
			.cell_out   (cell_out[p])
		);

		assign v_full[p]   = cell_out[p].v;
		assign act_full[p] = cell_out[p].active;
	end

	assign v_full[MAX_TOKENS]   = act_last_q | cell_out[MAX_TOKENS-1].carry;
	assign act_full[MAX_TOKENS] = act_last_q;
	assign accept_now           = v_full[n_use];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_start_q <= 1'b1;
			found_q      <= 1'b0;
			act_last_q   <= 1'b0;
		end else if (clear) begin
			line_start_q <= 1'b1;
			found_q      <= 1'b0;
			act_last_q   <= 1'b0;
		end else if (step) begin
			line_start_q <= 1'b0;
			// With an end anchor a match only counts when the line ends.
			found_q      <= found_q | (~anchor_end_q & accept_now);
			act_last_q   <= cell_out[MAX_TOKENS-1].advance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (clear) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			line_matched_q <= found_q | accept_now;
		end
	end

	assign out_valid    = out_valid_q;
	assign line_matched = line_matched_q;

	`SRLM_ASSERT_NEXT(a_eol_gives_result, clear, out_valid_q && line_start_q)
	`SRLM_ASSERT_NEXT(a_eol_clears_state, clear, (act_full == '0) && !found_q)
	`SRLM_ASSERT_NEXT(a_char_leaves_start, step, !line_start_q)
	`SRLM_ASSERT_SAME(a_stall_only_on_full_out, !in_ready, out_valid_q && !out_ready)

endmodule

`default_nettype wire
